>>> rtl/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg
// Shared constants, codes and types of the sample smoother.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HIST_DEPTH = 32;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int FRAC_W     = 16;
  localparam int EMA_W      = SAMPLE_W + FRAC_W;
  localparam int COEF_W     = FRAC_W + 1;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int SHORT_WIN  = 16;
  localparam int LONG_WIN   = 32;
  localparam int ONE_Q16    = 65536;

  localparam int PROD_W     = COEF_W + 1 + EMA_W + 1;
  localparam int ACC_W      = PROD_W + 1;

  localparam int NUM_W      = SUM_W + 2;
  localparam int DIV_MAG_W  = NUM_W - 1;
  localparam int DIV_DEN_W  = CNT_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_MAG_W);

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEF = 2'd1;

  localparam logic [MODE_W-1:0] MODE_AVG16 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AVG32 = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMA,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_MAG_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_MAG_W-1:0] quotient;
    logic                 rem_nz;
  } div_rsp_t;

endpackage

>>> rtl/mas_div.sv
// ----------------------------------------------------------------------------
// mas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mas_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mas_pkg::div_req_t req,
  output mas_pkg::div_rsp_t rsp
);
  import mas_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_MAG_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem_r, q_r[DIV_MAG_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_MAG_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_MAG_W-2:0], ge};
      rem_r <= ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;
  assign rsp.rem_nz   = |rem_r;

endmodule

>>> rtl/moving_average_or_exponential_smoother_top.sv
// ----------------------------------------------------------------------------
// moving_average_or_exponential_smoother_top
// Boxcar average over 16 or 32 words, or exponential smoothing in Q16.16.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_sample, in_start_of_record
//  out     | output    | out_valid/out_stall| out_smoothed_sample
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  a word in average modes passes through accept with history read, update with
//  coefficient multiply, ema add, serial divide by 2n and output load;
//  exponential mode skips the divide; in_stall is high from acceptance until the
//  result is loaded into the output register; a stalled output holds it back
//  synchronous reset clears pointer, count, sum and ema; history is not cleared
// ----------------------------------------------------------------------------
module moving_average_or_exponential_smoother_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mas_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_start_of_record,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mas_pkg::SAMPLE_W-1:0] out_smoothed_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mas_pkg::COEF_W-1:0]          cfg_data
);
  import mas_pkg::*;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]          mode_r;
  logic [COEF_W-1:0]          coef_r;
  logic [PTR_W-1:0]           wp_r;
  logic [CNT_W-1:0]           seen_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [EMA_W-1:0]    ema_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic                       first_r;
  logic                       neg_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

  logic                       accept;
  logic                       cfg_wr;
  logic                       box;
  logic                       out_free;
  logic [CNT_W-1:0]           win_len;
  logic [PTR_W-1:0]           wp_eff;
  logic [PTR_W-1:0]           old_addr;
  logic signed [SAMPLE_W-1:0] drop;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [EMA_W-1:0]    x_q16;
  logic signed [EMA_W:0]      diff;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [ACC_W-1:0]    ema_acc;
  logic signed [NUM_W-1:0]    num;
  logic signed [EMA_W:0]      ema_rnd;
  logic [SAMPLE_W-1:0]        box_res;
  logic [SAMPLE_W-1:0]        res;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  assign box      = (mode_r == MODE_AVG16) || (mode_r == MODE_AVG32);
  assign win_len  = (mode_r == MODE_AVG16) ? CNT_W'(SHORT_WIN) : CNT_W'(LONG_WIN);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr   = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;

  assign wp_eff   = in_start_of_record ? '0 : wp_r;
  assign old_addr = wp_eff - win_len[PTR_W-1:0];

  // window sum and ema difference product
  assign drop     = (seen_r >= win_len) ? rd_r : '0;
  assign sum_nxt  = sum_r - SUM_W'(drop) + SUM_W'(x_r);
  assign x_q16    = $signed({x_r, {FRAC_W{1'b0}}});
  assign diff     = (EMA_W+1)'(x_q16) - (EMA_W+1)'(ema_r);
  assign prod_nxt = $signed({1'b0, coef_r}) * diff;
  assign ema_acc  = ACC_W'($signed({ema_r, 1'b1, {(FRAC_W-1){1'b0}}})) + ACC_W'(prod_r);

  // divider operands: 2*sum + n over 2*n
  assign num = NUM_W'($signed({sum_r, 1'b0})) + NUM_W'(seen_r);
  assign div_req.start    = (state_r == ST_EMA) && box;
  assign div_req.dividend = num[NUM_W-1] ? DIV_MAG_W'(-num) : DIV_MAG_W'(num);
  assign div_req.divisor  = {seen_r, 1'b0};

  mas_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign box_res = neg_r ? (~div_rsp.quotient[SAMPLE_W-1:0] +
                            SAMPLE_W'(!div_rsp.rem_nz))
                         : div_rsp.quotient[SAMPLE_W-1:0];
  assign ema_rnd = (EMA_W+1)'(ema_r) + (EMA_W+1)'(ONE_Q16 / 2);
  assign res     = box ? box_res : ema_rnd[EMA_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_EMA;
      ST_EMA: begin
        state_nxt = box ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      coef_r      <= '0;
      wp_r        <= '0;
      seen_r      <= '0;
      sum_r       <= '0;
      ema_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_FILTER_MODE: begin
            mode_r <= cfg_data[MODE_W-1:0];
            wp_r   <= '0;
            seen_r <= '0;
            sum_r  <= '0;
            ema_r  <= '0;
          end
          CFG_SMOOTH_COEF: begin
            coef_r <= (cfg_data > COEF_W'(ONE_Q16)) ? COEF_W'(ONE_Q16) : cfg_data;
          end
          default: ;
        endcase
      end
      if (accept && in_start_of_record) begin
        wp_r   <= '0;
        seen_r <= '0;
        sum_r  <= '0;
        ema_r  <= '0;
      end
      if (state_r == ST_UPDATE) begin
        sum_r <= sum_nxt;
        wp_r  <= wp_r + 1'b1;
        if (seen_r < win_len) begin
          seen_r <= seen_r + 1'b1;
        end
      end
      if (state_r == ST_EMA) begin
        ema_r <= first_r ? x_q16 : ema_acc[EMA_W+FRAC_W-1:FRAC_W];
      end
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r  <= in_sample;
      rd_r <= hist_mem[old_addr];
    end
    if (state_r == ST_UPDATE) begin
      hist_mem[wp_r] <= x_r;
      first_r        <= (seen_r == '0);
      prod_r         <= prod_nxt;
    end
    if (state_r == ST_EMA) begin
      neg_r <= num[NUM_W-1];
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_smoothed_sample = out_data_r;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample smoother. A short table of directed
// words and register writes is followed by random phases over every filter
// mode and a spread of coefficients. A behavioural model in the bench
// predicts each smoothed word that the table gives no value for, and the
// output stream is compared in order. Both channels idle at random, and
// the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb;
  import mas_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_EMA     = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_EMA_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd2;
  localparam int NPLAN       = 28;
  localparam int NPHASE      = 12;
  localparam int PHASE_WORDS = 75;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [CFG_IDX_W-1:0]        idx;
    logic [COEF_W-1:0]           data;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        sor;
    logic                        known;
    logic signed [SAMPLE_W-1:0]  want;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_start_of_record = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_smoothed_sample;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_data = '0;

  logic signed [SAMPLE_W-1:0] expected_smoothed[$];
  int  mismatch_count = 0;
  bit  in_gap_enable = 1'b1;
  bit  stall_enable = 1'b1;
  bit  hold_request = 1'b0;

  // smoother state
  logic [MODE_W-1:0] cur_mode = MODE_AVG16;
  longint            cur_coef = 0;
  longint            tap_hist [HIST_DEPTH];
  int                tap_ptr = 0;
  int                tap_count = 0;
  longint            box_sum = 0;
  longint            ema_q16 = 0;

  row_t plan [NPLAN];

  moving_average_or_exponential_smoother_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_start_of_record  (in_start_of_record),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_smoothed_sample (out_smoothed_sample),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic void clear_history();
    tap_ptr = 0;
    tap_count = 0;
    box_sum = 0;
    ema_q16 = 0;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    if (idx == CFG_FILTER_MODE) begin
      cur_mode = data[MODE_W-1:0];
      clear_history();
    end else if (idx == CFG_SMOOTH_COEF) begin
      cur_coef = (data > ONE_Q16) ? ONE_Q16 : data;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] smooth_sample(
    logic signed [SAMPLE_W-1:0] x, logic sor);
    longint xs;
    longint prod;
    longint res;
    int     win;
    xs = x;
    win = (cur_mode == MODE_AVG16) ? SHORT_WIN : LONG_WIN;
    if (sor) begin
      clear_history();
    end
    if (tap_count == 0) begin
      ema_q16 = xs * ONE_Q16;
    end else begin
      prod = (ONE_Q16 - cur_coef) * ema_q16 + cur_coef * (xs * ONE_Q16);
      ema_q16 = div_floor(prod + 32768, ONE_Q16);
    end
    if (tap_count >= win) begin
      box_sum = box_sum - tap_hist[(tap_ptr + HIST_DEPTH - win) % HIST_DEPTH];
    end
    box_sum = box_sum + xs;
    tap_hist[tap_ptr] = xs;
    tap_ptr = (tap_ptr + 1) % HIST_DEPTH;
    if (tap_count < win) begin
      tap_count++;
    end
    if (cur_mode != MODE_AVG16 && cur_mode != MODE_AVG32) begin
      res = div_floor(ema_q16 + 32768, ONE_Q16);
    end else begin
      res = div_floor(2 * box_sum + tap_count, 2 * tap_count);
    end
    return res[SAMPLE_W-1:0];
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(10, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic sor, logic known,
                           logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] pred;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    in_start_of_record <= sor;
    do @(posedge clk); while (in_stall);
    pred = smooth_sample(s, sor);
    expected_smoothed.push_back(known ? want : pred);
    if (in_gap_enable && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (idle_len() - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_smoothed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver back-pressure
  always begin
    @(negedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
    end else if (!stall_enable || $urandom_range(0, 3) != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      repeat (idle_len() - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_smoothed.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %0d", $time,
                 out_smoothed_sample);
        mismatch_count++;
      end else begin
        want = expected_smoothed.pop_front();
        if (out_smoothed_sample !== want) begin
          $display("%0t: smoothed_sample expected %0d, got %0d", $time, want,
                   out_smoothed_sample);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int                         p;
    int                         w;
    logic [MODE_W-1:0]          mode;
    logic [COEF_W-1:0]          coef;
    logic signed [SAMPLE_W-1:0] s;
    logic                       sor;

    plan = '{
      '{ROW_WORD, '0, '0, 16'sd32767, 1'b1, 1'b1, 16'sd32767},
      '{ROW_WORD, '0, '0, 16'sh8000, 1'b0, 1'b1, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sh8000, 1'b1, 1'b1, 16'sh8000},
      '{ROW_WORD, '0, '0, 16'sd21845, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, -16'sd21846, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sd1, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, CFG_FILTER_MODE, {15'd0, MODE_AVG32}, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, -16'sd1, 1'b0, 1'b1, -16'sd1},
      '{ROW_WORD, '0, '0, 16'sd0, 1'b0, 1'b1, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sd12345, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, CFG_SMOOTH_COEF, 17'h1FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, CFG_FILTER_MODE, {15'd0, MODE_EMA}, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sd1000, 1'b0, 1'b1, 16'sd1000},
      '{ROW_WORD, '0, '0, 16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{ROW_WORD, '0, '0, 16'sd32767, 1'b0, 1'b1, 16'sd32767},
      '{ROW_REG, CFG_SMOOTH_COEF, 17'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sd5, 1'b0, 1'b1, 16'sd32767},
      '{ROW_WORD, '0, '0, 16'sd7, 1'b1, 1'b1, 16'sd7},
      '{ROW_WORD, '0, '0, -16'sd100, 1'b0, 1'b1, 16'sd7},
      '{ROW_REG, CFG_SMOOTH_COEF, 17'd32768, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, CFG_FILTER_MODE, {15'd0, MODE_EMA_ALT}, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sd100, 1'b1, 1'b1, 16'sd100},
      '{ROW_WORD, '0, '0, 16'sd0, 1'b0, 1'b1, 16'sd50},
      '{ROW_WORD, '0, '0, -16'sd1, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, CFG_SPARE, 17'h1FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sd3, 1'b0, 1'b0, 16'sd0},
      '{ROW_REG, CFG_FILTER_MODE, {15'd0, MODE_AVG16}, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WORD, '0, '0, 16'sh8000, 1'b0, 1'b1, 16'sh8000}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].sample, plan[i].sor, plan[i].known, plan[i].want);
      end
    end

    for (p = 0; p < NPHASE; p++) begin
      drain_results();
      mode = (p < 4) ? p[MODE_W-1:0] : MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       coef = '0;
        1:       coef = COEF_W'(ONE_Q16);
        2:       coef = COEF_W'(ONE_Q16 - 1);
        3:       coef = COEF_W'($urandom_range(ONE_Q16 + 1, 2 ** COEF_W - 1));
        default: coef = COEF_W'($urandom_range(0, ONE_Q16));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_SMOOTH_COEF, coef);
        write_reg(CFG_FILTER_MODE, {15'($urandom), mode});
      end else begin
        write_reg(CFG_FILTER_MODE, {15'($urandom), mode});
        write_reg(CFG_SMOOTH_COEF, coef);
      end
      in_gap_enable = (p % 4 != 1);
      stall_enable = (p % 4 != 1);
      // output held off while words keep coming
      if (p == 6) begin
        in_gap_enable = 1'b0;
        hold_request = 1'b1;
      end
      for (w = 0; w < PHASE_WORDS; w++) begin
        case ($urandom_range(0, 7))
          0:       s = 16'sh8000;
          1:       s = 16'sd32767;
          2:       s = SAMPLE_W'($urandom_range(0, 64) - 32);
          default: s = SAMPLE_W'($urandom);
        endcase
        sor = ($urandom_range(0, 39) == 0);
        if (p == 3 && w == PHASE_WORDS / 2) begin
          drain_results();
        end
        send_word(s, sor, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
